[rtl/mme_pkg.sv]
// shared types and constants for the matrix multiply engine
`default_nettype none

package mme_pkg;

  // widths fixed by the item fields and the configuration registers
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 6;
  localparam int VAL_W     = 16;
  localparam int PROD_W    = 38;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REQ    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] product;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     range_error;
  } res_t;

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_REQ
  } cmd_op_t;

  // classified command: request carries its range flag and clamped length
  typedef struct packed {
    cmd_op_t                 op;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    err;
    logic [CFG_W-1:0]        nk;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN,
    BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

[rtl/mme_front.sv]
// front end: configuration registers, item classification, queue push
`default_nettype none

module mme_front #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [mme_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mme_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                               in_valid,
  input  wire mme_pkg::item_t                     in_item,
  output logic                                    in_stall,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output mme_pkg::cmd_t                           q_cmd
);

  localparam int INNER_CAP_I = (MAX_INNER > 127) ? 127 : MAX_INNER;
  localparam logic [mme_pkg::CFG_W-1:0] INNER_CAP = INNER_CAP_I[mme_pkg::CFG_W-1:0];

  logic [mme_pkg::CFG_W-1:0] rows_a_r;
  logic [mme_pkg::CFG_W-1:0] inner_len_r;
  logic [mme_pkg::CFG_W-1:0] cols_b_r;
  logic                      keep;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= mme_pkg::CFG_RESET;
      inner_len_r <= mme_pkg::CFG_RESET;
      cols_b_r    <= mme_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mme_pkg::REG_ROWS_A:    rows_a_r    <= cfg_data;
        mme_pkg::REG_INNER_LEN: inner_len_r <= cfg_data;
        mme_pkg::REG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify: drop loads outside store geometry and unused kinds
  always_comb begin
    keep        = 1'b0;
    q_cmd.op    = mme_pkg::OP_REQ;
    q_cmd.row   = in_item.row;
    q_cmd.col   = in_item.col;
    q_cmd.value = in_item.value;
    q_cmd.err   = (int'(in_item.row) >= int'(rows_a_r)) || (int'(in_item.row) >= MAX_ROWS) ||
                  (int'(in_item.col) >= int'(cols_b_r)) || (int'(in_item.col) >= MAX_COLS);
    q_cmd.nk    = (int'(inner_len_r) > MAX_INNER) ? INNER_CAP : inner_len_r;
    case (in_item.kind)
      mme_pkg::KIND_LOAD_A: begin
        q_cmd.op = mme_pkg::OP_LOAD_A;
        keep     = (int'(in_item.row) < MAX_ROWS) && (int'(in_item.col) < MAX_INNER);
      end
      mme_pkg::KIND_LOAD_B: begin
        q_cmd.op = mme_pkg::OP_LOAD_B;
        keep     = (int'(in_item.row) < MAX_INNER) && (int'(in_item.col) < MAX_COLS);
      end
      mme_pkg::KIND_REQ: begin
        q_cmd.op = mme_pkg::OP_REQ;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  // accept whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

`default_nettype wire

[rtl/mme_queue.sv]
// short command queue between front and back
`default_nettype none

module mme_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mme_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output mme_pkg::cmd_t      head
);

  mme_pkg::cmd_t                entry_r [mme_pkg::QUEUE_DEPTH];
  logic [mme_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [mme_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [mme_pkg::QPTR_W:0]     cnt_r;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (cnt_r == (mme_pkg::QPTR_W+1)'(mme_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_cmd;
  end

endmodule

`default_nettype wire

[rtl/mme_back.sv]
// back end: element stores, dot product sequencer and result register
`default_nettype none

module mme_back #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire mme_pkg::cmd_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mme_pkg::res_t      out_res
);

  localparam int DEPTH_A = MAX_ROWS * MAX_INNER;
  localparam int DEPTH_B = MAX_INNER * MAX_COLS;
  localparam int AW_A    = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
  localparam int AW_B    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
  localparam int MUL_W   = 2 * mme_pkg::VAL_W;
  localparam int PW      = mme_pkg::PROD_W;

  mme_pkg::back_state_t state_r, state_nxt;

  logic signed [mme_pkg::VAL_W-1:0] mem_a [DEPTH_A];
  logic signed [mme_pkg::VAL_W-1:0] mem_b [DEPTH_B];

  logic [AW_A-1:0]                  addr_a_r;
  logic [AW_B-1:0]                  addr_b_r;
  logic [mme_pkg::CFG_W-1:0]        cnt_r;
  logic [mme_pkg::IDX_W-1:0]        row_r;
  logic [mme_pkg::IDX_W-1:0]        col_r;
  logic                             err_r;
  logic signed [mme_pkg::VAL_W-1:0] a_rd_r;
  logic signed [mme_pkg::VAL_W-1:0] b_rd_r;
  logic signed [MUL_W-1:0]          prod_r;
  logic signed [PW-1:0]             acc_r;
  logic                             p1_r, last1_r, p2_r, last2_r, done_r;
  logic                             out_valid_r;
  mme_pkg::res_t                    out_res_r;

  logic            wr_a, wr_b, start, issue, load_out;
  logic [AW_A-1:0] ld_addr_a, base_a;
  logic [AW_B-1:0] ld_addr_b;

  // store addresses of a load and the first A element of a request row
  always_comb begin
    int la_i;
    int lb_i;
    int ba_i;
    la_i      = int'(q_head.row) * MAX_INNER + int'(q_head.col);
    lb_i      = int'(q_head.row) * MAX_COLS + int'(q_head.col);
    ba_i      = int'(q_head.row) * MAX_INNER;
    ld_addr_a = la_i[AW_A-1:0];
    ld_addr_b = lb_i[AW_B-1:0];
    base_a    = ba_i[AW_A-1:0];
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and step controls
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    start     = 1'b0;
    issue     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      mme_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_head.op)
            mme_pkg::OP_LOAD_A: wr_a = 1'b1;
            mme_pkg::OP_LOAD_B: wr_b = 1'b1;
            mme_pkg::OP_REQ: begin
              start = 1'b1;
              if (q_head.err || (q_head.nk == '0)) begin
                state_nxt = mme_pkg::BK_EMIT;
              end else begin
                state_nxt = mme_pkg::BK_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      mme_pkg::BK_WALK: begin
        issue = 1'b1;
        if (cnt_r == mme_pkg::CFG_W'(1)) state_nxt = mme_pkg::BK_DRAIN;
      end
      mme_pkg::BK_DRAIN: begin
        if (done_r) state_nxt = mme_pkg::BK_EMIT;
      end
      mme_pkg::BK_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = mme_pkg::BK_IDLE;
        end
      end
      default: state_nxt = mme_pkg::BK_IDLE;
    endcase
  end

  // element stores: one write port for loads, one registered read port for the walk
  always_ff @(posedge clk) begin
    if (wr_a) mem_a[ld_addr_a] <= q_head.value;
    a_rd_r <= mem_a[addr_a_r];
  end

  always_ff @(posedge clk) begin
    if (wr_b) mem_b[ld_addr_b] <= q_head.value;
    b_rd_r <= mem_b[addr_b_r];
  end

  // walk counters and request fields
  always_ff @(posedge clk) begin
    if (start) begin
      row_r    <= q_head.row;
      col_r    <= q_head.col;
      err_r    <= q_head.err;
      cnt_r    <= q_head.nk;
      addr_a_r <= base_a;
      addr_b_r <= AW_B'(q_head.col);
    end else if (issue) begin
      cnt_r    <= cnt_r - 1'b1;
      addr_a_r <= addr_a_r + AW_A'(1);
      addr_b_r <= addr_b_r + AW_B'(MAX_COLS);
    end
  end

  // multiply-accumulate pipeline: read, multiply, add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r    <= 1'b0;
      last1_r <= 1'b0;
      p2_r    <= 1'b0;
      last2_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      p1_r    <= issue;
      last1_r <= issue && (cnt_r == mme_pkg::CFG_W'(1));
      p2_r    <= p1_r;
      last2_r <= last1_r;
      done_r  <= last2_r;
    end
  end

  // at most 127 terms of magnitude 2^30, so the 38-bit sum never overflows
  always_ff @(posedge clk) begin
    prod_r <= a_rd_r * b_rd_r;
    if (start) begin
      acc_r <= '0;
    end else if (p2_r) begin
      acc_r <= acc_r + {{(PW-MUL_W){prod_r[MUL_W-1]}}, prod_r};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r.product     <= acc_r;
      out_res_r.out_row     <= row_r;
      out_res_r.out_col     <= col_r;
      out_res_r.range_error <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // an error request never carries a nonzero sum
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.range_error |-> out_res_r.product == '0)
    else $error("range error result with nonzero product");

  // the walk never runs with an exhausted count
  a_walk_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mme_pkg::BK_WALK |-> cnt_r != '0)
    else $error("walk with zero count");

  // the last term lands only while draining
  a_done_drain: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == mme_pkg::BK_DRAIN)
    else $error("accumulate finished outside drain");

  // no pending result is overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_valid_r || !out_stall)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

[rtl/matrix_multiply_engine_core.sv]
// top level of the matrix multiply engine: front, command queue, back
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall   | mme_pkg::item_t (kind, row, col, value)
//  out     | output    | out_valid / out_stall | mme_pkg::res_t (product, out_row, out_col, range_error)
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// a load is written to its store as the back pops it; a product request is computed by the single
// multiply-accumulate that reads one A and one B element per cycle.
// error requests and requests with inner_len of zero skip the walk and go straight to the result.
// the front accepts items into a two-entry queue while the back is busy.
// reset is synchronous, active low; stores are not cleared; user reads only after loads (unenforced).
// a stalled result holds in the output register; the back waits until it is taken.
`default_nettype none

module matrix_multiply_engine_core #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mme_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire mme_pkg::item_t                in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output mme_pkg::res_t                      out_res
);

  logic          q_push, q_full, q_pop, q_empty;
  mme_pkg::cmd_t q_cmd, q_head;

  // classification and configuration
  mme_front #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  // command queue
  mme_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // stores and dot product
  mme_back #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire
